// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file rbd_checker.sv.
// Each macro takes a label, clock, active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define RBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/rbd_pkg.sv
// Shared types, constants and pixel helpers for the RAW10 BGGR downsampling debayer.
// No dependencies.
`default_nettype none

package rbd_pkg;

  localparam int GROUP_W = 40;
  localparam int PIX_W   = 10;
  localparam int CH_W    = 8;
  localparam int CNT_W   = 13;   // holds any group or row limit, up to 4096
  localparam int ROW_W   = 12;
  localparam int LANES   = 2;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam int MAX_GROUPS_DEF = 512;

  localparam logic [9:0]       ROW_GROUPS_RST = 10'd320;
  localparam logic [12:0]      FRAME_ROWS_RST = 13'd720;
  localparam logic [CNT_W-1:0] ROW_LIMIT      = 13'd4096;
  localparam logic [CNT_W-1:0] MIN_ROWS       = 13'd2;
  localparam logic [PIX_W-1:0] CH_MAX         = 10'd255;

  localparam logic REG_ROW_GROUPS = 1'b0;
  localparam logic REG_FRAME_ROWS = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] groups;   // groups per row after clamping
    logic [CNT_W-1:0] rows;     // rows per frame after clamping
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  // Pixel k of a packed group: high byte k, low two bits from byte 4.
  function automatic logic [PIX_W-1:0] pix_of(input logic [GROUP_W-1:0] grp,
                                              input logic [1:0] k);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [1:0] low2;
    lo = grp[39:32];
    case (k)
      2'd0: begin
        hi   = grp[7:0];
        low2 = lo[7:6];
      end
      2'd1: begin
        hi   = grp[15:8];
        low2 = lo[5:4];
      end
      2'd2: begin
        hi   = grp[23:16];
        low2 = lo[3:2];
      end
      default: begin
        hi   = grp[31:24];
        low2 = lo[1:0];
      end
    endcase
    return {hi, low2};
  endfunction

  function automatic logic [CH_W-1:0] sat8(input logic [PIX_W-1:0] v);
    return (v > CH_MAX) ? {CH_W{1'b1}} : v[CH_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/raw10_bggr_debayer_downsample.sv
// RAW10 BGGR 2x2 downsampling debayer, top level.
// Depends on rbd_pkg, rbd_cfg, rbd_ram and rbd_lane.
//
// Takes one five-byte RAW10 word per cycle while in_stall is low, row by row.
// Words of even rows go into a line store of MAX_GROUPS entries; each word
// of the next odd row is paired with the stored word above it and two lanes
// turn the two 2x2 cells into two RGB pixels (blue top-left, red
// bottom-right, green the floored mean of the two greens, all clipped to
// 255). Even-row words give no result. An odd-row word waits in the read
// stage for the line store's registered read, then passes through the lanes
// into the output register. in_stall rises only while both the read stage
// and the output register hold words and out_stall is high.
// Settle row_groups and frame_rows before a frame; the line store needs no
// clearing after reset.
`default_nettype none

module raw10_bggr_debayer_downsample #(
  parameter int MAX_GROUPS = rbd_pkg::MAX_GROUPS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rbd_pkg::GROUP_W-1:0]   in_packed_group,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [rbd_pkg::CH_W-1:0]      out_blue_first,
  output logic      [rbd_pkg::CH_W-1:0]      out_green_first,
  output logic      [rbd_pkg::CH_W-1:0]      out_red_first,
  output logic      [rbd_pkg::CH_W-1:0]      out_blue_second,
  output logic      [rbd_pkg::CH_W-1:0]      out_green_second,
  output logic      [rbd_pkg::CH_W-1:0]      out_red_second,
  output logic                               out_row_end,
  output logic                               out_frame_end,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rbd_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [rbd_pkg::DATA_W-1:0]    pwdata,
  output logic      [rbd_pkg::DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int GW = $clog2(MAX_GROUPS);
  localparam int CW = rbd_pkg::CNT_W;

  rbd_pkg::cfg_t cfg;

  rbd_cfg #(.MAX_GROUPS(MAX_GROUPS)) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // Position counters
  logic [GW-1:0]             grp_cnt_r, grp_cnt_nxt;
  logic [rbd_pkg::ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0]             g_ext, r_ext, last_odd;
  logic                      accept, odd_row, last_group, row_wrap, frame_last;

  assign accept     = in_valid && !in_stall;
  assign odd_row    = row_cnt_r[0];
  assign g_ext      = CW'(grp_cnt_r);
  assign r_ext      = CW'(row_cnt_r);
  assign last_group = (g_ext + CW'(1)) >= cfg.groups;
  assign row_wrap   = (r_ext + CW'(1)) >= cfg.rows;
  assign last_odd   = (cfg.rows & ~CW'(1)) - CW'(1);
  assign frame_last = last_group && (r_ext >= last_odd);

  always_comb begin
    grp_cnt_nxt = grp_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (accept) begin
      if (last_group) begin
        grp_cnt_nxt = '0;
        row_cnt_nxt = row_wrap ? '0 : row_cnt_r + 1'b1;
      end else begin
        grp_cnt_nxt = grp_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      grp_cnt_r <= grp_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // Line store: even rows write, odd rows read the word above
  logic [rbd_pkg::GROUP_W-1:0] top_word;

  rbd_ram #(.WIDTH(rbd_pkg::GROUP_W), .DEPTH(MAX_GROUPS)) u_line (
    .clk  (clk),
    .we   (accept && !odd_row),
    .waddr(grp_cnt_r),
    .wdata(in_packed_group),
    .re   (accept && odd_row),
    .raddr(grp_cnt_r),
    .rdata(top_word)
  );

  // Read stage: holds the bottom word while the line store read completes
  logic                        s1_valid_r, s1_valid_nxt;
  logic [rbd_pkg::GROUP_W-1:0] s1_bot_r;
  logic                        s1_row_end_r, s1_frame_end_r;
  logic                        adv1;

  assign adv1     = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !adv1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept && odd_row) begin
      s1_valid_nxt = 1'b1;
    end else if (adv1) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && odd_row) begin
      s1_bot_r       <= in_packed_group;
      s1_row_end_r   <= last_group;
      s1_frame_end_r <= frame_last;
    end
  end

  // Lanes: lane l covers pixels 2l and 2l+1 of both rows
  rbd_pkg::rgb_t lane_pix [rbd_pkg::LANES];

  for (genvar l = 0; l < rbd_pkg::LANES; l++) begin : g_lane
    rbd_lane u_lane (
      .top_left (rbd_pkg::pix_of(top_word, 2'(2 * l))),
      .top_right(rbd_pkg::pix_of(top_word, 2'(2 * l + 1))),
      .bot_left (rbd_pkg::pix_of(s1_bot_r, 2'(2 * l))),
      .bot_right(rbd_pkg::pix_of(s1_bot_r, 2'(2 * l + 1))),
      .pix      (lane_pix[l])
    );
  end

  // Merge lanes into the output register
  logic          out_valid_r, out_valid_nxt;
  rbd_pkg::rgb_t out_first_r, out_second_r;
  logic          out_row_end_r, out_frame_end_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv1) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      out_first_r     <= lane_pix[0];
      out_second_r    <= lane_pix[1];
      out_row_end_r   <= s1_row_end_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_blue_first   = out_first_r.blue;
  assign out_green_first  = out_first_r.green;
  assign out_red_first    = out_first_r.red;
  assign out_blue_second  = out_second_r.blue;
  assign out_green_second = out_second_r.green;
  assign out_red_second   = out_second_r.red;
  assign out_row_end      = out_row_end_r;
  assign out_frame_end    = out_frame_end_r;

endmodule

`default_nettype wire

// File: hw/rtl/rbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rbd_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rbd_cfg.sv
// APB-style register file: row_groups and frame_rows, plus their clamped values.
// Depends on rbd_pkg.
`default_nettype none

module rbd_cfg #(
  parameter int MAX_GROUPS = rbd_pkg::MAX_GROUPS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rbd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rbd_pkg::DATA_W-1:0]  pwdata,
  output logic      [rbd_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output rbd_pkg::cfg_t                    cfg
);

  localparam logic [rbd_pkg::CNT_W-1:0] MaxGroups = rbd_pkg::CNT_W'(MAX_GROUPS);

  logic [9:0]  row_groups_r, row_groups_nxt;
  logic [12:0] frame_rows_r, frame_rows_nxt;
  logic        reg_idx;
  logic        wr;
  logic [rbd_pkg::CNT_W-1:0] rg_ext;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr      = psel && penable && pwrite;

  always_comb begin
    row_groups_nxt = row_groups_r;
    frame_rows_nxt = frame_rows_r;
    if (wr) begin
      case (reg_idx)
        rbd_pkg::REG_ROW_GROUPS: row_groups_nxt = pwdata[9:0];
        rbd_pkg::REG_FRAME_ROWS: frame_rows_nxt = pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_groups_r <= rbd_pkg::ROW_GROUPS_RST;
      frame_rows_r <= rbd_pkg::FRAME_ROWS_RST;
    end else begin
      row_groups_r <= row_groups_nxt;
      frame_rows_r <= frame_rows_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      rbd_pkg::REG_ROW_GROUPS: prdata = rbd_pkg::DATA_W'(row_groups_r);
      rbd_pkg::REG_FRAME_ROWS: prdata = rbd_pkg::DATA_W'(frame_rows_r);
      default:                 prdata = '0;
    endcase
  end

  // Clamp: zero groups act as one, groups stop at MAX_GROUPS, rows stay within 2..4096.
  assign rg_ext = rbd_pkg::CNT_W'(row_groups_r);

  always_comb begin
    if (rg_ext == '0) begin
      cfg.groups = rbd_pkg::CNT_W'(1);
    end else if (rg_ext > MaxGroups) begin
      cfg.groups = MaxGroups;
    end else begin
      cfg.groups = rg_ext;
    end
    if (frame_rows_r < rbd_pkg::MIN_ROWS) begin
      cfg.rows = rbd_pkg::MIN_ROWS;
    end else if (frame_rows_r > rbd_pkg::ROW_LIMIT) begin
      cfg.rows = rbd_pkg::ROW_LIMIT;
    end else begin
      cfg.rows = frame_rows_r;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rbd_lane.sv
// One debayer lane: a 2x2 BGGR cell to one saturated RGB pixel.
// Depends on rbd_pkg.
`default_nettype none

module rbd_lane (
  input  wire logic [rbd_pkg::PIX_W-1:0] top_left,
  input  wire logic [rbd_pkg::PIX_W-1:0] top_right,
  input  wire logic [rbd_pkg::PIX_W-1:0] bot_left,
  input  wire logic [rbd_pkg::PIX_W-1:0] bot_right,
  output rbd_pkg::rgb_t                  pix
);

  logic [rbd_pkg::PIX_W:0] green_sum;

  assign green_sum = {1'b0, top_right} + {1'b0, bot_left};

  assign pix.blue  = rbd_pkg::sat8(top_left);
  assign pix.green = rbd_pkg::sat8(green_sum[rbd_pkg::PIX_W:1]);
  assign pix.red   = rbd_pkg::sat8(bot_right);

endmodule

`default_nettype wire

// File: hw/rtl/rbd_checker.sv
// Port-level checker for the debayer top level, attached by bind.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rbd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_blue_first,
  input wire logic       out_row_end,
  input wire logic       out_frame_end
);

  // Hold a stalled result word
  `RBD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `RBD_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_blue_first))
  // The frame's last word also closes its row
  `RBD_ASSERT_IMP(a_frame_row, clk, rst_n, out_valid && out_frame_end, out_row_end)
  // Input back-pressure only comes from a blocked output
  `RBD_ASSERT_IMP(a_stall_src, clk, rst_n, in_stall, out_valid && out_stall)

endmodule

bind raw10_bggr_debayer_downsample rbd_checker u_rbd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_blue_first(out_blue_first),
  .out_row_end   (out_row_end),
  .out_frame_end (out_frame_end)
);

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for raw10_bggr_debayer_downsample: a scoreboard class predicts
// each RGB pixel pair from the accepted RAW10 words. Depends on rbd_pkg and the block's RTL.

module tb_top;

  localparam int LINE_DEPTH = 512;
  localparam int CYCLE_LIMIT = 600000;
  localparam int NPHASES = 10;

  typedef struct packed {
    logic [7:0] blue_first;
    logic [7:0] green_first;
    logic [7:0] red_first;
    logic [7:0] blue_second;
    logic [7:0] green_second;
    logic [7:0] red_second;
    logic       row_end;
    logic       frame_end;
  } rgb_pair_t;

  class rgb_pair_scoreboard;
    logic [rbd_pkg::GROUP_W-1:0] upper_row[LINE_DEPTH];
    bit          row_written[LINE_DEPTH];
    int unsigned group_pos;
    int unsigned row_pos;
    int unsigned row_groups;
    int unsigned frame_rows;
    rgb_pair_t   pairs_due[$];
    int          errors;

    function new();
      group_pos  = 0;
      row_pos    = 0;
      row_groups = 320;
      frame_rows = 720;
      errors     = 0;
      foreach (row_written[k]) row_written[k] = 0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    function int unsigned pending();
      return pairs_due.size();
    endfunction

    function void set_reg(logic idx, int unsigned val);
      if (idx == rbd_pkg::REG_ROW_GROUPS) row_groups = val & 32'h3ff;
      else frame_rows = val & 32'h1fff;
    endfunction

    function int unsigned clamp_groups(int unsigned n);
      if (n < 1) return 1;
      if (n > LINE_DEPTH) return LINE_DEPTH;
      return n;
    endfunction

    function int unsigned clamp_rows(int unsigned n);
      if (n < 2) return 2;
      if (n > 4096) return 4096;
      return n;
    endfunction

    // A new width is safe only if an odd row in progress finds every word above it stored.
    function bit groups_fit(int unsigned n);
      int unsigned lim;
      lim = clamp_groups(n & 32'h3ff);
      if (row_pos[0] == 1'b0) return 1;
      for (int k = 0; k < lim; k++)
        if (!row_written[k]) return 0;
      return 1;
    endfunction

    function logic [9:0] raw_pixel(logic [rbd_pkg::GROUP_W-1:0] w, int k);
      return {w[8*k +: 8], w[32 + 2*(3-k) +: 2]};
    endfunction

    function logic [7:0] clip8(logic [10:0] v);
      return (v > 11'd255) ? 8'hff : v[7:0];
    endfunction

    function void accept_raw_word(logic [rbd_pkg::GROUP_W-1:0] w);
      int unsigned groups;
      int unsigned rows;
      int unsigned last_odd;
      bit          last_group;
      logic [rbd_pkg::GROUP_W-1:0] top;
      rgb_pair_t   px;
      groups     = clamp_groups(row_groups);
      rows       = clamp_rows(frame_rows);
      last_group = (group_pos + 1 >= groups);
      if (row_pos[0] == 1'b0) begin
        if (group_pos < LINE_DEPTH) begin
          upper_row[group_pos]   = w;
          row_written[group_pos] = 1;
        end
      end else begin
        top = upper_row[group_pos];
        last_odd = (rows & ~32'd1) - 1;
        px.blue_first   = clip8({1'b0, raw_pixel(top, 0)});
        px.green_first  = clip8(({1'b0, raw_pixel(top, 1)} + {1'b0, raw_pixel(w, 0)}) >> 1);
        px.red_first    = clip8({1'b0, raw_pixel(w, 1)});
        px.blue_second  = clip8({1'b0, raw_pixel(top, 2)});
        px.green_second = clip8(({1'b0, raw_pixel(top, 3)} + {1'b0, raw_pixel(w, 2)}) >> 1);
        px.red_second   = clip8({1'b0, raw_pixel(w, 3)});
        px.row_end      = last_group;
        px.frame_end    = last_group && (row_pos >= last_odd);
        pairs_due.push_back(px);
      end
      if (last_group) begin
        group_pos = 0;
        row_pos   = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
      end else begin
        group_pos++;
      end
    endfunction

    task cmp(string field, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task check_pair(rgb_pair_t got);
      rgb_pair_t want;
      if (pairs_due.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = pairs_due.pop_front();
      cmp("blue_first",   got.blue_first,   want.blue_first);
      cmp("green_first",  got.green_first,  want.green_first);
      cmp("red_first",    got.red_first,    want.red_first);
      cmp("blue_second",  got.blue_second,  want.blue_second);
      cmp("green_second", got.green_second, want.green_second);
      cmp("red_second",   got.red_second,   want.red_second);
      cmp("row_end",      got.row_end,      want.row_end);
      cmp("frame_end",    got.frame_end,    want.frame_end);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [rbd_pkg::GROUP_W-1:0] in_packed_group;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_blue_first, out_green_first, out_red_first;
  logic [7:0] out_blue_second, out_green_second, out_red_second;
  logic out_row_end, out_frame_end;
  logic psel, penable, pwrite, pready;
  logic [rbd_pkg::ADDR_W-1:0] paddr;
  logic [rbd_pkg::DATA_W-1:0] pwdata, prdata;

  rgb_pair_scoreboard sb;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned stall_hold;
  int unsigned cycles;

  raw10_bggr_debayer_downsample dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_packed_group(in_packed_group),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_blue_first(out_blue_first), .out_green_first(out_green_first),
    .out_red_first(out_red_first), .out_blue_second(out_blue_second),
    .out_green_second(out_green_second), .out_red_second(out_red_second),
    .out_row_end(out_row_end), .out_frame_end(out_frame_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, with a long hold-off while stall_hold runs down.
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_stall = 1'b1;
      stall_hold--;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_pair('{out_blue_first, out_green_first, out_red_first, out_blue_second,
                      out_green_second, out_red_second, out_row_end, out_frame_end});
  end

  function automatic logic [rbd_pkg::GROUP_W-1:0] pack_pixels(
      logic [9:0] p0, logic [9:0] p1, logic [9:0] p2, logic [9:0] p3);
    return {p0[1:0], p1[1:0], p2[1:0], p3[1:0], p3[9:2], p2[9:2], p1[9:2], p0[9:2]};
  endfunction

  function automatic logic [9:0] pick_pixel(int unsigned style);
    case (style)
      0: return 10'($urandom_range(0, 1023));
      1: return 10'($urandom_range(0, 255));
      2: return 10'($urandom_range(248, 264));
      default: return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
    endcase
  endfunction

  function automatic logic [rbd_pkg::GROUP_W-1:0] random_word();
    logic [63:0] wide;
    int unsigned style;
    style = $urandom_range(0, 4);
    if (style == 4) begin
      wide = {$urandom, $urandom};
      return wide[rbd_pkg::GROUP_W-1:0];
    end
    return pack_pixels(pick_pixel(style), pick_pixel(style), pick_pixel(style),
                       pick_pixel(style));
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic [rbd_pkg::GROUP_W-1:0] w);
    logic [63:0] junk;
    while ($urandom_range(0, 99) < idle_pct) begin
      junk = {$urandom, $urandom};
      in_valid = 1'b0;
      in_packed_group = junk[rbd_pkg::GROUP_W-1:0];
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_packed_group = w;
    do @(posedge clk); while (in_stall);
    sb.accept_raw_word(w);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic apb_cycle(logic wr, logic idx, logic [31:0] data, output logic [31:0] rd);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    logic [31:0] rd;
    logic [31:0] mask;
    mask = (idx == rbd_pkg::REG_ROW_GROUPS) ? 32'h3ff : 32'h1fff;
    apb_cycle(1'b1, idx, val & mask, rd);
    sb.set_reg(idx, val);
    apb_cycle(1'b0, idx, 32'd0, rd);
    if (rd != (val & mask))
      sb.report($sformatf("register %0d read %0d expected %0d", idx, rd, val & mask));
  endtask

  // Drain results, then let even-row words still in flight settle.
  task automatic settle();
    while (sb.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  int unsigned ph_groups[NPHASES] = '{4, 0, 7, 3, 512, 1023, 1, 1, 5, 6};
  int unsigned ph_rows[NPHASES]   = '{6, 1, 5, 4, 2, 0, 4096, 8191, 7, 9};
  int unsigned ph_items[NPHASES]  = '{70, 40, 70, 70, 130, 90, 110, 90, 60, 60};
  int unsigned ph_idle[NPHASES]   = '{0, 53, 0, 31, 0, 53, 0, 31, 53, 31};
  int unsigned ph_stall[NPHASES]  = '{0, 0, 53, 31, 0, 0, 53, 0, 0, 31};

  logic [rbd_pkg::GROUP_W-1:0] opening[12];

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_packed_group = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    stall_hold = 0;
    cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Two tiny frames of three rows: the last even row of each has no partner.
    write_reg(rbd_pkg::REG_ROW_GROUPS, 2);
    write_reg(rbd_pkg::REG_FRAME_ROWS, 3);
    opening[0]  = pack_pixels(10'd0, 10'd0, 10'd1023, 10'd1023);
    opening[1]  = pack_pixels(10'd255, 10'd256, 10'd254, 10'd255);
    opening[2]  = pack_pixels(10'd1023, 10'd0, 10'd1023, 10'd1023);
    opening[3]  = pack_pixels(10'd255, 10'd257, 10'd256, 10'd1);
    opening[4]  = 40'hff_ffff_ffff;
    opening[5]  = 40'h00_0000_0000;
    opening[6]  = pack_pixels(10'd256, 10'd510, 10'd1, 10'd2);
    opening[7]  = 40'hff_ffff_ffff;
    opening[8]  = pack_pixels(10'd0, 10'd1, 10'd2, 10'd3);
    opening[9]  = 40'hff_ffff_ffff;
    opening[10] = 40'haa_5555_aaaa;
    opening[11] = 40'h55_aaaa_5555;
    foreach (opening[i]) send_word(opening[i]);

    for (int p = 0; p < NPHASES; p++) begin
      settle();
      // Phases end mid-frame, so these writes also exercise kept counters.
      if (sb.groups_fit(ph_groups[p])) write_reg(rbd_pkg::REG_ROW_GROUPS, ph_groups[p]);
      write_reg(rbd_pkg::REG_FRAME_ROWS, ph_rows[p]);
      idle_pct  = ph_idle[p];
      stall_pct = ph_stall[p];
      // Hold the output long enough to back the block up into its input.
      if (p == 2) stall_hold = 150;
      for (int i = 0; i < ph_items[p]; i++) begin
        if (p == 3 && i == 40)
          while (sb.pending() != 0) @(negedge clk);
        send_word(random_word());
      end
    end

    idle_pct = 0;
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rbd_pkg.sv
hw/rtl/rbd_ram.sv
hw/rtl/rbd_cfg.sv
hw/rtl/rbd_lane.sv
hw/rtl/raw10_bggr_debayer_downsample.sv
hw/rtl/rbd_checker.sv
dv/tb_top.sv
